>>> sv/hsvg_pkg.sv
package hsvg_pkg;

  // Default count of fractional bits in the fixed-point datapath.
  localparam int FRAC_BITS_DEF = 16;

  // Register stages from input to output: lookup, chroma, blend, place, gamma.
  localparam int NUM_STAGES = 5;

  // Hue sector, floor(hue * 6 / 255). The wrap code only occurs at hue 255.
  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5,
    SEC_WRAP   = 3'd6
  } sector_t;

  // Load enables, one per register stage.
  typedef struct packed {
    logic lut;
    logic chroma;
    logic blend;
    logic place;
    logic rom;
  } stage_en_t;

  // Gamma ROM entry k: the largest y in 0..255 with y^11 <= k^5 * 255^6,
  // which is floor(255 * (k/255)^(1/2.2)). Evaluated at elaboration only.
  function automatic logic [7:0] gamma_entry(input int unsigned k);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [7:0]   y;
    logic [7:0]   cand;
    int           i;
    int           b;
    rhs = 128'd1;
    for (i = 0; i < 5; i++) rhs = rhs * 128'(k & 32'hFF);
    for (i = 0; i < 6; i++) rhs = rhs * 128'd255;
    y = 8'd0;
    for (b = 7; b >= 0; b--) begin
      cand = y | (8'd1 << b);
      lhs  = 128'd1;
      for (i = 0; i < 11; i++) lhs = lhs * 128'(cand);
      if (lhs <= rhs) y = cand;
    end
    return y;
  endfunction

endpackage

>>> sv/hsvg_lut.sv
module hsvg_lut #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  hsvg_pkg::stage_en_t      en,
  input  logic [7:0]               hue,
  input  logic [7:0]               saturation,
  input  logic [7:0]               brightness,
  output logic [FRAC_BITS:0]       vf,
  output logic [FRAC_BITS:0]       sf,
  output hsvg_pkg::sector_t        sector,
  output logic [FRAC_BITS-1:0]     frac
);
  import hsvg_pkg::*;

  localparam int FW = FRAC_BITS + 1;

  // Byte to fixed point (255 maps to one), and per-hue sector and fraction.
  logic [FW-1:0]        fix_tab [256];
  sector_t              sec_tab [256];
  logic [FRAC_BITS-1:0] frac_tab [256];

  for (genvar i = 0; i < 256; i++) begin : g_tab
    localparam logic [FW-1:0] FIXV = FW'((64'(i) << FRAC_BITS) / 64'd255);
    localparam sector_t SECV = sector_t'(3'((i * 6) / 255));
    localparam logic [FRAC_BITS-1:0] FRV =
      FRAC_BITS'(((64'((i * 6) % 255)) << FRAC_BITS) / 64'd255);
    assign fix_tab[i]  = FIXV;
    assign sec_tab[i]  = SECV;
    assign frac_tab[i] = FRV;
  end

  always_ff @(posedge clk) begin
    if (en.lut) begin
      vf     <= fix_tab[brightness];
      sf     <= fix_tab[saturation];
      sector <= sec_tab[hue];
      frac   <= frac_tab[hue];
    end
  end

endmodule

>>> sv/hsvg_chroma.sv
module hsvg_chroma #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  hsvg_pkg::stage_en_t      en,
  input  logic [FRAC_BITS:0]       vf_in,
  input  logic [FRAC_BITS:0]       sf_in,
  input  hsvg_pkg::sector_t        sector_in,
  input  logic [FRAC_BITS-1:0]     frac_in,
  output logic [FRAC_BITS:0]       c,
  output logic [FRAC_BITS:0]       x,
  output logic [FRAC_BITS:0]       m,
  output hsvg_pkg::sector_t        sector
);
  import hsvg_pkg::*;

  localparam int FW = FRAC_BITS + 1;
  localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [2*FW-1:0]      prod_c;
  logic [FW-1:0]        c_a;
  logic [FW-1:0]        vf_a;
  sector_t              sector_a;
  logic [FRAC_BITS-1:0] frac_a;
  logic [FW-1:0]        weight;
  logic [2*FW-1:0]      prod_x;

  // Chroma c = v * s.
  assign prod_c = {{FW{1'b0}}, vf_in} * {{FW{1'b0}}, sf_in};

  always_ff @(posedge clk) begin
    if (en.chroma) begin
      c_a      <= prod_c[FRAC_BITS +: FW];
      vf_a     <= vf_in;
      sector_a <= sector_in;
      frac_a   <= frac_in;
    end
  end

  // Falling edge of the triangle in odd sectors.
  assign weight = sector_a[0] ? (ONE - {1'b0, frac_a}) : {1'b0, frac_a};
  assign prod_x = {{FW{1'b0}}, c_a} * {{FW{1'b0}}, weight};

  always_ff @(posedge clk) begin
    if (en.blend) begin
      c      <= c_a;
      x      <= prod_x[FRAC_BITS +: FW];
      m      <= vf_a - c_a;
      sector <= sector_a;
    end
  end

endmodule

>>> sv/hsvg_place.sv
module hsvg_place #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  hsvg_pkg::stage_en_t  en,
  input  logic [FRAC_BITS:0]   c,
  input  logic [FRAC_BITS:0]   x,
  input  logic [FRAC_BITS:0]   m,
  input  hsvg_pkg::sector_t    sector,
  output logic [7:0]           idx_r,
  output logic [7:0]           idx_g,
  output logic [7:0]           idx_b
);
  import hsvg_pkg::*;

  localparam int FW = FRAC_BITS + 1;
  localparam int SW = FW + 8;
  localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

  logic [FW-1:0] pr;
  logic [FW-1:0] pg;
  logic [FW-1:0] pb;

  // Channel in 0..one to a rounded ROM index: (chan * 255 + one/2) >> FRAC_BITS.
  function automatic logic [7:0] to_index(input logic [FW-1:0] chan);
    logic [SW-1:0] s;
    s = {chan, 8'd0} - {8'd0, chan} + HALF;
    return s[FRAC_BITS +: 8];
  endfunction

  always_comb begin
    unique case (sector)
      SEC_R_TO_Y: begin
        pr = c; pg = x; pb = '0;
      end
      SEC_Y_TO_G: begin
        pr = x; pg = c; pb = '0;
      end
      SEC_G_TO_C: begin
        pr = '0; pg = c; pb = x;
      end
      SEC_C_TO_B: begin
        pr = '0; pg = x; pb = c;
      end
      SEC_B_TO_M: begin
        pr = x; pg = '0; pb = c;
      end
      SEC_M_TO_R, SEC_WRAP: begin
        pr = c; pg = '0; pb = x;
      end
      default: begin
        pr = c; pg = '0; pb = x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.place) begin
      idx_r <= to_index(FW'(pr + m));
      idx_g <= to_index(FW'(pg + m));
      idx_b <= to_index(FW'(pb + m));
    end
  end

endmodule

>>> sv/hsvg_gamma.sv
module hsvg_gamma (
  input  logic                 clk,
  input  hsvg_pkg::stage_en_t  en,
  input  logic [7:0]           idx_r,
  input  logic [7:0]           idx_g,
  input  logic [7:0]           idx_b,
  output logic [7:0]           red,
  output logic [7:0]           green,
  output logic [7:0]           blue
);
  import hsvg_pkg::*;

  logic [7:0] gamma_tab [256];

  for (genvar i = 0; i < 256; i++) begin : g_rom
    localparam logic [7:0] GV = gamma_entry(i);
    assign gamma_tab[i] = GV;
  end

  always_ff @(posedge clk) begin
    if (en.rom) begin
      red   <= gamma_tab[idx_r];
      green <= gamma_tab[idx_g];
      blue  <= gamma_tab[idx_b];
    end
  end

endmodule

>>> sv/hsv_to_rgb_gamma_core.sv
// HSV to gamma-corrected RGB converter. Takes one pixel (hue, saturation,
// brightness, each read as x/255) per clock while hsv_stall is low, and
// returns the 8-bit PWM duties red, green and blue after a 1/2.2 gamma,
// truncated. There are five register stages: byte-to-fixed-point and hue
// lookup, chroma multiply, blend multiply, sector placement with ROM index
// rounding, and the 256-entry gamma ROM.
// Each stage carries a valid bit and loads whenever it is empty or its
// successor moves, so bubbles collapse and rgb_stall only backs up the
// input once every stage holds an item. FRAC_BITS (8..24) sets the width
// of the fixed-point datapath.
module hsv_to_rgb_gamma_core #(
  parameter int FRAC_BITS = hsvg_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       hsv_valid,
  output logic       hsv_stall,
  input  logic [7:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  output logic       rgb_valid,
  input  logic       rgb_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);
  import hsvg_pkg::*;

  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] stage_valid_next;
  logic [NUM_STAGES-1:0] stage_open;
  stage_en_t             en;

  logic [FRAC_BITS:0]    vf;
  logic [FRAC_BITS:0]    sf;
  sector_t               sector_l;
  logic [FRAC_BITS-1:0]  frac;
  logic [FRAC_BITS:0]    c;
  logic [FRAC_BITS:0]    x;
  logic [FRAC_BITS:0]    m;
  sector_t               sector_b;
  logic [7:0]            idx_r;
  logic [7:0]            idx_g;
  logic [7:0]            idx_b;

  // A stage may load when it is empty or its item moves on this cycle.
  always_comb begin
    stage_open[NUM_STAGES-1] = ~stage_valid[NUM_STAGES-1] | ~rgb_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_open[k] = ~stage_valid[k] | stage_open[k+1];
    end
  end

  assign en.lut    = stage_open[0];
  assign en.chroma = stage_open[1];
  assign en.blend  = stage_open[2];
  assign en.place  = stage_open[3];
  assign en.rom    = stage_open[4];

  // Advance valid bits with their items; hold a stage that cannot move.
  always_comb begin
    stage_valid_next[0] = stage_open[0] ? hsv_valid : stage_valid[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      stage_valid_next[k] = stage_open[k] ? stage_valid[k-1] : stage_valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  assign hsv_stall = ~stage_open[0];
  assign rgb_valid = stage_valid[NUM_STAGES-1];

  hsvg_lut #(.FRAC_BITS(FRAC_BITS)) u_lut (
    .clk        (clk),
    .en         (en),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .vf         (vf),
    .sf         (sf),
    .sector     (sector_l),
    .frac       (frac)
  );

  hsvg_chroma #(.FRAC_BITS(FRAC_BITS)) u_chroma (
    .clk       (clk),
    .en        (en),
    .vf_in     (vf),
    .sf_in     (sf),
    .sector_in (sector_l),
    .frac_in   (frac),
    .c         (c),
    .x         (x),
    .m         (m),
    .sector    (sector_b)
  );

  hsvg_place #(.FRAC_BITS(FRAC_BITS)) u_place (
    .clk    (clk),
    .en     (en),
    .c      (c),
    .x      (x),
    .m      (m),
    .sector (sector_b),
    .idx_r  (idx_r),
    .idx_g  (idx_g),
    .idx_b  (idx_b)
  );

  hsvg_gamma u_gamma (
    .clk   (clk),
    .en    (en),
    .idx_r (idx_r),
    .idx_g (idx_g),
    .idx_b (idx_b),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

  // An accepted item lands in the first stage.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && !hsv_stall |=> stage_valid[0])
    else $error("accepted item missing from first stage");

  // The input backs up only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    hsv_stall |-> (&stage_valid))
    else $error("input stalled with an empty stage");

  // A blocked inner stage keeps its item.
  a_inner_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid[2] && !stage_open[2] |=> stage_valid[2] && $stable(x) && $stable(c))
    else $error("blocked blend stage lost its item");

endmodule
